@@ sv/qbt_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// qbt_pkg
// Shared types, constants and helpers for the quote/bracket aware tokenizer.
// ============================================================================
package qbt_pkg;

    localparam int MAX_LINE  = 4096;
    localparam int POS_W     = $clog2(MAX_LINE);
    localparam int LEN_W     = POS_W + 1;
    localparam int MAX_DEPTH = 255;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [7:0] SEPARATOR_RESET = CH_SPACE;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_PLAIN   = 3'd1,
        MODE_QUOTE   = 3'd2,
        MODE_BRACKET = 3'd3,
        MODE_AFTER   = 3'd4
    } mode_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic             token_valid;
        logic [POS_W-1:0] token_start;
        logic [LEN_W-1:0] token_length;
        logic             end_of_line;
        logic             line_overflow;
    } out_item_t;

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_SQUOTE) || (c == CH_DQUOTE);
    endfunction

    function automatic logic is_open_bracket(input logic [7:0] c);
        return (c == CH_LBRACE) || (c == CH_LBRACKET) || (c == CH_LPAREN);
    endfunction

    function automatic logic [7:0] close_of(input logic [7:0] c);
        logic [7:0] r;
        r = CH_RPAREN;
        if (c == CH_LBRACE)
        begin
            r = CH_RBRACE;
        end
        else if (c == CH_LBRACKET)
        begin
            r = CH_RBRACKET;
        end
        return r;
    endfunction

endpackage

@@ sv/qbt_in_stage.sv @@
`timescale 1ns / 1ps
// ============================================================================
// qbt_in_stage
// Input register: holds one item until the scan stage consumes it.
// ============================================================================
module qbt_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  qbt_pkg::in_item_t in_data,
    output logic              item_valid,
    output qbt_pkg::in_item_t item,
    input  logic              item_take
);

    logic              valid_reg;
    logic              valid_next;
    qbt_pkg::in_item_t data_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

@@ sv/qbt_scan.sv @@
`timescale 1ns / 1ps
// ============================================================================
// qbt_scan
// Per-byte scanner: line state, group tracking and token result forming.
// ============================================================================
module qbt_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  logic               item_valid,
    input  qbt_pkg::in_item_t  item,
    input  logic               out_free,
    output logic               item_take,
    output logic               result_load,
    output qbt_pkg::out_item_t result
);

    logic [7:0]                   separator_reg;
    qbt_pkg::mode_t               mode_reg, mode_next;
    logic [7:0]                   close_reg, close_next;
    logic [7:0]                   open_reg, open_next;
    logic [qbt_pkg::DEPTH_W-1:0]  depth_reg, depth_next;
    logic [7:0]                   prev_reg, prev_next;
    logic [qbt_pkg::LEN_W-1:0]    pos_reg, pos_next;
    logic [qbt_pkg::POS_W-1:0]    begin_reg, begin_next;
    logic [qbt_pkg::POS_W-1:0]    lns_reg, lns_next;
    logic                         ovf_reg, ovf_next;

    logic [qbt_pkg::POS_W-1:0]    idx;
    logic [qbt_pkg::DEPTH_W-1:0]  depth_dec;
    logic [7:0]                   c;
    logic                         last;
    logic                         emit;
    logic                         has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= qbt_pkg::SEPARATOR_RESET;
        end
        else if (cfg_we)
        begin
            separator_reg <= cfg_data;
        end
    end

    always_comb
    begin
        c          = item.char_in;
        last       = item.last_in;
        mode_next  = mode_reg;
        close_next = close_reg;
        open_next  = open_reg;
        depth_next = depth_reg;
        begin_next = begin_reg;
        lns_next   = lns_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        emit       = 1'b0;
        depth_dec  = '0;
        result     = '0;

        if (pos_reg >= qbt_pkg::LEN_W'(qbt_pkg::MAX_LINE))
        begin
            idx      = qbt_pkg::POS_W'(qbt_pkg::MAX_LINE - 1);
            ovf_next = 1'b1;
        end
        else
        begin
            idx      = pos_reg[qbt_pkg::POS_W-1:0];
            pos_next = pos_reg + 1'b1;
        end

        unique case (mode_reg)
            qbt_pkg::MODE_IDLE:
            begin
                if (qbt_pkg::is_quote(c))
                begin
                    mode_next  = qbt_pkg::MODE_QUOTE;
                    close_next = c;
                    open_next  = c;
                    begin_next = idx;
                    lns_next   = idx;
                end
                else if (qbt_pkg::is_open_bracket(c))
                begin
                    mode_next  = qbt_pkg::MODE_BRACKET;
                    open_next  = c;
                    close_next = qbt_pkg::close_of(c);
                    depth_next = qbt_pkg::DEPTH_W'(1);
                    begin_next = idx;
                    lns_next   = idx;
                end
                else if (c != qbt_pkg::CH_SPACE && c != separator_reg)
                begin
                    mode_next  = qbt_pkg::MODE_PLAIN;
                    begin_next = idx;
                    lns_next   = idx;
                end
            end
            qbt_pkg::MODE_PLAIN:
            begin
                if (c == separator_reg)
                begin
                    emit = 1'b1;
                end
                else if (c != qbt_pkg::CH_SPACE)
                begin
                    lns_next = idx;
                end
            end
            qbt_pkg::MODE_QUOTE:
            begin
                if (c != qbt_pkg::CH_SPACE)
                begin
                    lns_next = idx;
                end
                if (c == close_reg && prev_reg != qbt_pkg::CH_BACKSLASH)
                begin
                    mode_next = qbt_pkg::MODE_AFTER;
                end
            end
            qbt_pkg::MODE_BRACKET:
            begin
                if (c != qbt_pkg::CH_SPACE)
                begin
                    lns_next = idx;
                end
                if (c == close_reg)
                begin
                    depth_dec  = (depth_reg != '0) ? depth_reg - 1'b1 : '0;
                    depth_next = depth_dec;
                    if (depth_dec == '0)
                    begin
                        mode_next = qbt_pkg::MODE_AFTER;
                    end
                end
                else if (c == open_reg)
                begin
                    if (depth_reg < qbt_pkg::DEPTH_W'(qbt_pkg::MAX_DEPTH))
                    begin
                        depth_next = depth_reg + 1'b1;
                    end
                end
            end
            qbt_pkg::MODE_AFTER:
            begin
                if (qbt_pkg::is_quote(c))
                begin
                    mode_next  = qbt_pkg::MODE_QUOTE;
                    close_next = c;
                    open_next  = c;
                    lns_next   = idx;
                end
                else if (qbt_pkg::is_open_bracket(c))
                begin
                    mode_next  = qbt_pkg::MODE_BRACKET;
                    open_next  = c;
                    close_next = qbt_pkg::close_of(c);
                    depth_next = qbt_pkg::DEPTH_W'(1);
                    lns_next   = idx;
                end
                else if (c == separator_reg)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    mode_next = qbt_pkg::MODE_PLAIN;
                    if (c != qbt_pkg::CH_SPACE)
                    begin
                        lns_next = idx;
                    end
                end
            end
            default:
            begin
                mode_next = qbt_pkg::MODE_IDLE;
            end
        endcase

        prev_next = c;

        if (!emit && last && mode_next != qbt_pkg::MODE_IDLE)
        begin
            emit = 1'b1;
        end

        if (emit)
        begin
            result.token_valid  = 1'b1;
            result.token_start  = begin_next;
            result.token_length = {1'b0, lns_next} - {1'b0, begin_next} + 1'b1;
            mode_next           = qbt_pkg::MODE_IDLE;
        end
        result.end_of_line   = last;
        result.line_overflow = ovf_next;

        has_result = emit || last;

        // line end returns all line state to its reset value
        if (last)
        begin
            mode_next  = qbt_pkg::MODE_IDLE;
            close_next = '0;
            open_next  = '0;
            depth_next = '0;
            prev_next  = '0;
            pos_next   = '0;
            begin_next = '0;
            lns_next   = '0;
            ovf_next   = 1'b0;
        end
    end

    assign item_take   = item_valid && (!has_result || out_free);
    assign result_load = item_take && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= qbt_pkg::MODE_IDLE;
            close_reg <= '0;
            open_reg  <= '0;
            depth_reg <= '0;
            prev_reg  <= '0;
            pos_reg   <= '0;
            begin_reg <= '0;
            lns_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (item_take)
        begin
            mode_reg  <= mode_next;
            close_reg <= close_next;
            open_reg  <= open_next;
            depth_reg <= depth_next;
            prev_reg  <= prev_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            lns_reg   <= lns_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

@@ sv/qbt_out_stage.sv @@
`timescale 1ns / 1ps
// ============================================================================
// qbt_out_stage
// Result register: holds one result item until the consumer takes it.
// ============================================================================
module qbt_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               result_load,
    input  qbt_pkg::out_item_t result,
    output logic               out_free,
    output logic               out_valid,
    input  logic               out_ready,
    output qbt_pkg::out_item_t out_data
);

    logic               valid_reg;
    logic               valid_next;
    qbt_pkg::out_item_t data_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = result_load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ sv/quote_bracket_aware_tokenizer_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// quote_bracket_aware_tokenizer_top
// Command-line tokenizer, one byte per item, quote and bracket aware.
// ============================================================================
//  channel   handshake             payload
//  -------   -------------------   ----------------------------------------
//  in        in_valid/in_ready     in_data  : char_in, last_in
//  out       out_valid/out_ready   out_data : token_valid, token_start,
//                                             token_length, end_of_line,
//                                             line_overflow
//  cfg       cfg_we                cfg_data : separator
//
//  One byte per cycle sustained unless a held result stalls the scan; the
//  per-byte scan is a single combinational stage between the input register
//  and the result register; each result item is offered from that register.
//  Reset clears line state and sets the separator to a space.
//  A held result stalls only bytes that produce a result; others pass.
// ============================================================================
module quote_bracket_aware_tokenizer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qbt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output qbt_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data
);

    logic               item_valid;
    qbt_pkg::in_item_t  item;
    logic               item_take;
    logic               out_free;
    logic               result_load;
    qbt_pkg::out_item_t result;

    qbt_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    qbt_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item        (item),
        .out_free    (out_free),
        .item_take   (item_take),
        .result_load (result_load),
        .result      (result)
    );

    qbt_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .result_load (result_load),
        .result      (result),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the quote/bracket aware command-line tokenizer.
// Bytes go in one per item. A scoreboard tracks the scan state, works out
// the token that each accepted byte should finish, and compares every result
// item field by field. Several separator settings are used, with random
// stalls on both channels, a long receiver hold and one deeply nested line.
// ============================================================================

function automatic logic [7:0] closing_of(input logic [7:0] o);
    case (o)
        qbt_pkg::CH_LBRACE:   return qbt_pkg::CH_RBRACE;
        qbt_pkg::CH_LBRACKET: return qbt_pkg::CH_RBRACKET;
        default:              return qbt_pkg::CH_RPAREN;
    endcase
endfunction

class token_scoreboard;
    logic [7:0]         sep_byte;
    qbt_pkg::mode_t     scan;
    logic [7:0]         close_ch;
    logic [7:0]         open_ch;
    logic [7:0]         prev_ch;
    int unsigned        depth;
    int unsigned        pos;
    int unsigned        tok_begin;
    int unsigned        last_ns;
    bit                 overflow;
    qbt_pkg::out_item_t expected_tokens[$];
    int unsigned        errors;

    function new();
        sep_byte = qbt_pkg::SEPARATOR_RESET;
        errors   = 0;
        clear_line();
    endfunction

    function void clear_line();
        scan      = qbt_pkg::MODE_IDLE;
        close_ch  = '0;
        open_ch   = '0;
        depth     = 0;
        prev_ch   = '0;
        pos       = 0;
        tok_begin = 0;
        last_ns   = 0;
        overflow  = 1'b0;
    endfunction

    function void set_separator(logic [7:0] v);
        sep_byte = v;
    endfunction

    function int pending();
        return expected_tokens.size();
    endfunction

    function bit try_open_group(logic [7:0] c);
        if (c == qbt_pkg::CH_SQUOTE || c == qbt_pkg::CH_DQUOTE)
        begin
            scan     = qbt_pkg::MODE_QUOTE;
            open_ch  = c;
            close_ch = c;
            return 1'b1;
        end
        if (c == qbt_pkg::CH_LBRACE || c == qbt_pkg::CH_LBRACKET || c == qbt_pkg::CH_LPAREN)
        begin
            scan     = qbt_pkg::MODE_BRACKET;
            open_ch  = c;
            close_ch = closing_of(c);
            depth    = 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void note_byte(qbt_pkg::in_item_t item);
        logic [7:0]         c;
        bit                 fin;
        bit                 emit;
        int unsigned        idx;
        qbt_pkg::out_item_t r;
        c    = item.char_in;
        fin  = item.last_in;
        emit = 1'b0;
        if (pos >= qbt_pkg::MAX_LINE)
        begin
            idx      = qbt_pkg::MAX_LINE - 1;
            overflow = 1'b1;
        end
        else
        begin
            idx = pos;
            pos++;
        end
        case (scan)
            qbt_pkg::MODE_IDLE:
            begin
                if (try_open_group(c))
                begin
                    tok_begin = idx;
                    last_ns   = idx;
                end
                else if (c != qbt_pkg::CH_SPACE && c != sep_byte)
                begin
                    tok_begin = idx;
                    last_ns   = idx;
                    scan      = qbt_pkg::MODE_PLAIN;
                end
            end
            qbt_pkg::MODE_PLAIN:
            begin
                if (c == sep_byte)
                    emit = 1'b1;
                else if (c != qbt_pkg::CH_SPACE)
                    last_ns = idx;
            end
            qbt_pkg::MODE_QUOTE:
            begin
                if (c != qbt_pkg::CH_SPACE)
                    last_ns = idx;
                if (c == close_ch && prev_ch != qbt_pkg::CH_BACKSLASH)
                    scan = qbt_pkg::MODE_AFTER;
            end
            qbt_pkg::MODE_BRACKET:
            begin
                if (c != qbt_pkg::CH_SPACE)
                    last_ns = idx;
                if (c == close_ch)
                begin
                    if (depth > 0)
                        depth--;
                    if (depth == 0)
                        scan = qbt_pkg::MODE_AFTER;
                end
                else if (c == open_ch)
                begin
                    if (depth < qbt_pkg::MAX_DEPTH)
                        depth++;
                end
            end
            default:
            begin
                if (try_open_group(c))
                    last_ns = idx;
                else if (c == sep_byte)
                    emit = 1'b1;
                else
                begin
                    scan = qbt_pkg::MODE_PLAIN;
                    if (c != qbt_pkg::CH_SPACE)
                        last_ns = idx;
                end
            end
        endcase
        prev_ch = c;
        // an open token is closed out by the end of the line
        if (!emit && fin && scan != qbt_pkg::MODE_IDLE)
            emit = 1'b1;
        if (emit || fin)
        begin
            r.token_valid   = emit;
            r.token_start   = emit ? qbt_pkg::POS_W'(tok_begin) : '0;
            r.token_length  = emit ? qbt_pkg::LEN_W'(last_ns - tok_begin + 1) : '0;
            r.end_of_line   = fin;
            r.line_overflow = overflow;
            expected_tokens = {expected_tokens, r};
        end
        if (emit)
            scan = qbt_pkg::MODE_IDLE;
        if (fin)
            clear_line();
    endfunction

    function void check_token(qbt_pkg::out_item_t got);
        qbt_pkg::out_item_t want;
        if (expected_tokens.size() == 0)
        begin
            $error("unexpected result item %p", got);
            errors++;
            return;
        end
        want = expected_tokens.pop_front();
        if (got.token_valid !== want.token_valid)
        begin
            $error("token_valid: expected %0d, actual %0d", want.token_valid, got.token_valid);
            errors++;
        end
        if (got.token_start !== want.token_start)
        begin
            $error("token_start: expected %0d, actual %0d", want.token_start, got.token_start);
            errors++;
        end
        if (got.token_length !== want.token_length)
        begin
            $error("token_length: expected %0d, actual %0d",
                   want.token_length, got.token_length);
            errors++;
        end
        if (got.end_of_line !== want.end_of_line)
        begin
            $error("end_of_line: expected %0d, actual %0d", want.end_of_line, got.end_of_line);
            errors++;
        end
        if (got.line_overflow !== want.line_overflow)
        begin
            $error("line_overflow: expected %0d, actual %0d",
                   want.line_overflow, got.line_overflow);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int LATENCY        = 2;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    qbt_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    qbt_pkg::out_item_t out_data;
    logic               cfg_we;
    logic [7:0]         cfg_data;

    token_scoreboard tokens = new();

    logic [7:0]  line_buf[$];
    logic [7:0]  cur_sep = qbt_pkg::SEPARATOR_RESET;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned stall_cycles = 0;

    always #4 clk = ~clk;

    quote_bracket_aware_tokenizer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tokens.note_byte(in_data);
            if (out_valid && out_ready)
                tokens.check_token(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver: random back-pressure, plus one long hold on request
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic void put_byte(input logic [7:0] b);
        line_buf = {line_buf, b};
    endfunction

    function automatic logic [7:0] open_kind();
        case ($urandom_range(0, 2))
            0:       return qbt_pkg::CH_LBRACE;
            1:       return qbt_pkg::CH_LBRACKET;
            default: return qbt_pkg::CH_LPAREN;
        endcase
    endfunction

    function automatic logic [7:0] pick_byte(input logic [7:0] sep_now);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 50)
            return qbt_pkg::CH_SPACE;
        if (r < 62)
            return sep_now;
        if (r < 70)
            return $urandom_range(0, 1) ? qbt_pkg::CH_SQUOTE : qbt_pkg::CH_DQUOTE;
        if (r < 77)
            return open_kind();
        if (r < 84)
            return closing_of(open_kind());
        if (r < 89)
            return qbt_pkg::CH_BACKSLASH;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_word(input logic [7:0] sep_now);
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 9) == 0)
                put_byte(pick_byte(sep_now));
            else
                put_byte(8'h61 + 8'($urandom_range(0, 25)));
        end
    endfunction

    function automatic void add_quoted(input logic [7:0] sep_now);
        logic [7:0] q;
        q = $urandom_range(0, 1) ? qbt_pkg::CH_SQUOTE : qbt_pkg::CH_DQUOTE;
        put_byte(q);
        repeat ($urandom_range(0, 6))
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                put_byte(qbt_pkg::CH_BACKSLASH);
                put_byte(q);
            end
            else
                put_byte(pick_byte(sep_now));
        end
        if ($urandom_range(0, 9) != 0)
            put_byte(q);
    endfunction

    function automatic void add_bracketed(input logic [7:0] sep_now, input int lvl);
        logic [7:0] o;
        o = open_kind();
        put_byte(o);
        repeat ($urandom_range(0, 4))
        begin
            if (lvl > 0 && $urandom_range(0, 2) == 0)
                add_bracketed(sep_now, lvl - 1);
            else
                put_byte(pick_byte(sep_now));
        end
        if ($urandom_range(0, 9) != 0)
            put_byte(closing_of(o));
    endfunction

    function automatic void build_line(input logic [7:0] sep_now);
        int unsigned n_tok;
        line_buf.delete();
        n_tok = $urandom_range(1, 4);
        for (int unsigned t = 0; t < n_tok; t++)
        begin
            repeat ($urandom_range(0, 2)) put_byte(qbt_pkg::CH_SPACE);
            case ($urandom_range(0, 4))
                0, 1: add_word(sep_now);
                2:    add_quoted(sep_now);
                3:    add_bracketed(sep_now, 2);
                default:
                begin
                    add_quoted(sep_now);
                    add_bracketed(sep_now, 1);
                    add_word(sep_now);
                end
            endcase
            repeat ($urandom_range(0, 2)) put_byte(qbt_pkg::CH_SPACE);
            if (t + 1 < n_tok || $urandom_range(0, 1) == 1)
                put_byte(sep_now);
        end
    endfunction

    function automatic void build_noise(input logic [7:0] sep_now);
        int unsigned r;
        line_buf.delete();
        r = $urandom_range(0, 9);
        repeat ($urandom_range(1, 16))
        begin
            if (r == 0)
                put_byte($urandom_range(0, 1) ? qbt_pkg::CH_SPACE : sep_now);
            else if ($urandom_range(0, 1) == 0)
                put_byte(pick_byte(sep_now));
            else
                put_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_item(input qbt_pkg::in_item_t item);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_line();
        qbt_pkg::in_item_t item;
        foreach (line_buf[i])
        begin
            item.char_in = line_buf[i];
            item.last_in = (i == line_buf.size() - 1);
            send_item(item);
        end
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
        send_line();
    endtask

    task automatic run_lines(input int unsigned budget);
        int unsigned sent;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 75)
                build_line(cur_sep);
            else
                build_noise(cur_sep);
            sent += line_buf.size();
            send_line();
        end
    endtask

    // same-kind nesting past the depth limit, then the closes that unwind it
    task automatic send_deep_line();
        line_buf.delete();
        repeat (qbt_pkg::MAX_DEPTH + 3) put_byte(qbt_pkg::CH_LPAREN);
        repeat (qbt_pkg::MAX_DEPTH) put_byte(qbt_pkg::CH_RPAREN);
        add_word(cur_sep);
        put_byte(cur_sep);
        put_byte(8'h7A);
        send_line();
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tokens.pending() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_separator(input logic [7:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tokens.set_separator(v);
        cur_sep = v;
    endtask

    initial
    begin
        logic [7:0]        phase_seps [7];
        qbt_pkg::in_item_t item;
        phase_seps = '{8'h2C, 8'h00, 8'hFF, qbt_pkg::CH_DQUOTE, qbt_pkg::CH_LPAREN,
                       8'h00, qbt_pkg::CH_SPACE};
        phase_seps[5] = 8'($urandom_range(0, 255));

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 15;
        snk_idle_pct = 15;
        send_text("ab");
        send_text("\"a b\"x");
        send_text("'a\\'b'");
        send_text("{{}}(c");
        send_text(" ");
        item.char_in = 8'hFF;
        item.last_in = 1'b0;
        send_item(item);
        item.char_in = 8'h00;
        item.last_in = 1'b1;
        send_item(item);
        drain_block();

        write_separator(8'h2C);
        send_deep_line();
        drain_block();

        for (int p = 0; p < 7; p++)
        begin
            write_separator(phase_seps[p]);
            src_idle_pct = 10 * $urandom_range(0, 3);
            snk_idle_pct = 10 * $urandom_range(0, 3);
            if (p == 1)
                hold_req = 1'b1;
            run_lines(50);
            drain_block();
        end

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_lines(50);
        drain_block();

        if (tokens.errors == 0 && tokens.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
sv/qbt_pkg.sv
sv/qbt_in_stage.sv
sv/qbt_scan.sv
sv/qbt_out_stage.sv
sv/quote_bracket_aware_tokenizer_top.sv
dv/testbench.sv
